@@ hdl/wvc_pkg.sv @@
// Shared constants, widths and the arctangent table for the waypoint velocity controller.
// Depends on nothing; every file of the block but wvc_delay imports it.
package wvc_pkg;

   localparam int ANGLE_ITER_DEF = 16;
   localparam int ATAN_ENTRIES   = 24;

   // angle datapath
   localparam int DIFF_W   = 34;   // vector components entering the rotator
   localparam int NORM_W   = 42;   // after normalisation
   localparam int NORM_TOP = 39;   // leading one lands here
   localparam int ROT_W    = 44;   // rotation stages
   localparam int ZW       = 35;   // accumulated angle, Q.30
   localparam int ANG_W    = 18;   // rounded angle, Q3.13

   // distance and speed datapath
   localparam int SQ_IN_W = 63;
   localparam int ROOT_W  = 32;
   localparam int DIST_W  = 33;
   localparam int NUM_W   = 54;
   localparam int DEN_W   = 24;
   localparam int QUO_W   = 41;
   localparam int ERR_W   = 19;
   localparam int MAG_W   = 18;

   localparam int ISQ_LAT      = ROOT_W + 1;
   localparam int DIV_LAT      = QUO_W + 1;
   localparam int MERGE_STAGE  = 4 + ISQ_LAT;
   localparam int PIPE_LATENCY = MERGE_STAGE + 2 + DIV_LAT + 3;

   localparam logic signed [ERR_W-1:0] PI_Q13     = 19'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 19'sd51472;
   localparam logic signed [ZW-1:0]    PI_Q30     = 35'sd3373259426;

   function automatic int cordic_lat(input int iter);
      return ((iter > ATAN_ENTRIES) ? ATAN_ENTRIES : iter) + 5;
   endfunction

   // atan(2^-i) in Q.30, truncated
   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0:  val = 35'sh03243F6A8;
         1:  val = 35'sh01DAC6705;
         2:  val = 35'sh00FADBAFC;
         3:  val = 35'sh007F56EA6;
         4:  val = 35'sh003FEAB76;
         5:  val = 35'sh001FFD55B;
         6:  val = 35'sh000FFFAAA;
         7:  val = 35'sh0007FFF55;
         8:  val = 35'sh0003FFFEA;
         9:  val = 35'sh0001FFFFD;
         10: val = 35'sh0000FFFFF;
         11: val = 35'sh00007FFFF;
         12: val = 35'sh00003FFFF;
         13: val = 35'sh00001FFFF;
         14: val = 35'sh00000FFFF;
         15: val = 35'sh000007FFF;
         16: val = 35'sh000003FFF;
         17: val = 35'sh000001FFF;
         18: val = 35'sh000000FFF;
         19: val = 35'sh0000007FF;
         20: val = 35'sh0000003FF;
         21: val = 35'sh0000001FF;
         22: val = 35'sh0000000FF;
         23: val = 35'sh00000007F;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ hdl/wvc_delay.sv @@
// Valid-tagged delay line that keeps side data in step with the long pipelined units.
// Depends on nothing.
module wvc_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] data_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff[0] <= in_data;
      for (int k = 1; k < DEPTH; k++) begin
         data_ff[k] <= data_ff[k-1];
      end
   end

   assign out_valid = vld_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];
endmodule

@@ hdl/wvc_cordic.sv @@
// Pipelined vectoring rotator: normalise, fold into the right half plane, then one
// rotation per stage; returns atan2(y, x) in Q3.13. Depends on wvc_pkg.
module wvc_cordic
   import wvc_pkg::*;
#(
   parameter int ITERATIONS = ANGLE_ITER_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [DIFF_W-1:0] in_x,
   input  logic signed [DIFF_W-1:0] in_y,
   output logic                     out_valid,
   output logic signed [ANG_W-1:0]  out_angle
);
   localparam int STEPS = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;
   localparam int LAT   = STEPS + 5;
   localparam logic [NORM_W-1:0] LIM32 = NORM_W'(1) << (NORM_TOP + 1 - 32);
   localparam logic [NORM_W-1:0] LIM16 = NORM_W'(1) << (NORM_TOP + 1 - 16);
   localparam logic [NORM_W-1:0] LIM8  = NORM_W'(1) << (NORM_TOP + 1 - 8);
   localparam logic [NORM_W-1:0] LIM4  = NORM_W'(1) << (NORM_TOP + 1 - 4);
   localparam logic [NORM_W-1:0] LIM2  = NORM_W'(1) << (NORM_TOP + 1 - 2);
   localparam logic [NORM_W-1:0] LIM1  = NORM_W'(1) << (NORM_TOP + 1 - 1);

   logic [LAT-1:0] vld_ff;

   logic signed [NORM_W-1:0] x0_in, y0_in, x0_ff, y0_ff;
   logic signed [NORM_W-1:0] x1_in, y1_in, x1_ff, y1_ff;
   logic signed [NORM_W-1:0] x2_in, y2_in, x2_ff, y2_ff;
   logic [NORM_W-1:0]        m0_in, m0_ff, m1_in, m1_ff, m2_in;
   logic [NORM_W-1:0]        ax, ay;
   logic signed [ROT_W-1:0]  x3_in, y3_in;
   logic signed [ZW-1:0]     z3_in;
   logic signed [ROT_W-1:0]  xr_ff [0:STEPS];
   logic signed [ROT_W-1:0]  yr_ff [0:STEPS];
   logic signed [ZW-1:0]     zr_ff [0:STEPS];
   logic signed [ZW-1:0]     z_round;
   logic signed [ANG_W-1:0]  angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_comb begin
      x0_in = NORM_W'(in_x);
      y0_in = NORM_W'(in_y);
      ax    = x0_in[NORM_W-1] ? $unsigned(-x0_in) : $unsigned(x0_in);
      ay    = y0_in[NORM_W-1] ? $unsigned(-y0_in) : $unsigned(y0_in);
      m0_in = (ax > ay) ? ax : ay;
   end

   // coarse normalising shifts
   always_comb begin
      x1_in = x0_ff;
      y1_in = y0_ff;
      m1_in = m0_ff;
      if (m1_in < LIM32) begin
         x1_in = x1_in <<< 32;
         y1_in = y1_in <<< 32;
         m1_in = m1_in << 32;
      end
      if (m1_in < LIM16) begin
         x1_in = x1_in <<< 16;
         y1_in = y1_in <<< 16;
         m1_in = m1_in << 16;
      end
      if (m1_in < LIM8) begin
         x1_in = x1_in <<< 8;
         y1_in = y1_in <<< 8;
         m1_in = m1_in << 8;
      end
   end

   // fine normalising shifts
   always_comb begin
      x2_in = x1_ff;
      y2_in = y1_ff;
      m2_in = m1_ff;
      if (m2_in < LIM4) begin
         x2_in = x2_in <<< 4;
         y2_in = y2_in <<< 4;
         m2_in = m2_in << 4;
      end
      if (m2_in < LIM2) begin
         x2_in = x2_in <<< 2;
         y2_in = y2_in <<< 2;
         m2_in = m2_in << 2;
      end
      if (m2_in < LIM1) begin
         x2_in = x2_in <<< 1;
         y2_in = y2_in <<< 1;
      end
   end

   // fold the left half plane over, starting the angle at plus or minus pi
   always_comb begin
      x3_in = ROT_W'(x2_ff);
      y3_in = ROT_W'(y2_ff);
      z3_in = '0;
      if (x2_ff[NORM_W-1]) begin
         z3_in = y2_ff[NORM_W-1] ? -PI_Q30 : PI_Q30;
         x3_in = -x3_in;
         y3_in = -y3_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      m0_ff <= m0_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      m1_ff <= m1_in;
      x2_ff <= x2_in;
      y2_ff <= y2_in;
      xr_ff[0] <= x3_in;
      yr_ff[0] <= y3_in;
      zr_ff[0] <= z3_in;
      for (int k = 0; k < STEPS; k++) begin
         if (!yr_ff[k][ROT_W-1]) begin
            xr_ff[k+1] <= xr_ff[k] + (yr_ff[k] >>> k);
            yr_ff[k+1] <= yr_ff[k] - (xr_ff[k] >>> k);
            zr_ff[k+1] <= zr_ff[k] + atan_q30(k);
         end else begin
            xr_ff[k+1] <= xr_ff[k] - (yr_ff[k] >>> k);
            yr_ff[k+1] <= yr_ff[k] + (xr_ff[k] >>> k);
            zr_ff[k+1] <= zr_ff[k] - atan_q30(k);
         end
      end
      angle_ff <= z_round[ZW-1:17];
   end

   assign z_round   = zr_ff[STEPS] + (ZW'(1) <<< 16);
   assign out_valid = vld_ff[LAT-1];
   assign out_angle = angle_ff;
endmodule

@@ hdl/wvc_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, floor of the root.
// Depends on wvc_pkg.
module wvc_isqrt
   import wvc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [SQ_IN_W-1:0] in_value,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root
);
   localparam int ACC_W = SQ_IN_W + 1;

   logic [ROOT_W:0]    vld_ff;
   logic [ACC_W-1:0]   rem_ff   [0:ROOT_W];
   logic [ACC_W-1:0]   res_ff   [0:ROOT_W];
   logic [ACC_W-1:0]   trial    [0:ROOT_W-1];
   logic [ACC_W-1:0]   bit_val  [0:ROOT_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ROOT_W-1:0], in_valid};
      end
   end

   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         bit_val[k] = ACC_W'(1) << (2 * (ROOT_W - 1 - k));
         trial[k]   = res_ff[k] + bit_val[k];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= ACC_W'(in_value);
      res_ff[0] <= '0;
      for (int k = 0; k < ROOT_W; k++) begin
         if (rem_ff[k] >= trial[k]) begin
            rem_ff[k+1] <= rem_ff[k] - trial[k];
            res_ff[k+1] <= (res_ff[k] >> 1) + bit_val[k];
         end else begin
            rem_ff[k+1] <= rem_ff[k];
            res_ff[k+1] <= res_ff[k] >> 1;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = res_ff[ROOT_W][ROOT_W-1:0];
endmodule

@@ hdl/wvc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, floor quotient.
// Depends on wvc_pkg; the divisor is never below 8192, which bounds the quotient.
module wvc_div
   import wvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo
);
   localparam int WIDE_W = DEN_W + QUO_W - 1;

   logic [QUO_W:0]      vld_ff;
   logic [NUM_W-1:0]    rem_ff [0:QUO_W];
   logic [DEN_W-1:0]    den_ff [0:QUO_W];
   logic [QUO_W-1:0]    quo_ff [0:QUO_W];
   logic [WIDE_W-1:0]   sub    [0:QUO_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QUO_W-1:0], in_valid};
      end
   end

   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         sub[k] = WIDE_W'(den_ff[k]) << (QUO_W - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= in_num;
      den_ff[0] <= in_den;
      quo_ff[0] <= '0;
      for (int k = 0; k < QUO_W; k++) begin
         den_ff[k+1] <= den_ff[k];
         if (WIDE_W'(rem_ff[k]) >= sub[k]) begin
            rem_ff[k+1] <= rem_ff[k] - NUM_W'(sub[k]);
            quo_ff[k+1] <= quo_ff[k] | (QUO_W'(1) << (QUO_W - 1 - k));
         end else begin
            rem_ff[k+1] <= rem_ff[k];
            quo_ff[k+1] <= quo_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
endmodule

@@ hdl/waypoint_velocity_controller.sv @@
// Top level of the waypoint velocity controller: input stages, two angle rotators,
// square root, divider, speed and turn shaping, register port. Depends on wvc_pkg.
//
// One pose transaction is taken every clock cycle outside reset. Its command passes
// stages A to D, the square root, stages F and G, the divider and stages R, S and T,
// and is driven onto the rsp_ ports strobed by rsp_valid for one cycle.
// The delay is set by the 33-stage square root on the distance and the 42-stage
// divider behind it; the two angle rotators are padded to match at any iteration count.
// The receiver cannot hold results off, so nothing stalls; busy is high only in reset.
// Write the gain and limit registers only when no transaction is in flight.
module waypoint_velocity_controller
   import wvc_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_robot_x,
   input  logic signed [31:0] req_robot_y,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [31:0] req_goal_x,
   input  logic signed [31:0] req_goal_y,
   output logic               rsp_valid,
   output logic [23:0]        rsp_forward_speed,
   output logic signed [15:0] rsp_turn_rate,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   localparam logic [2:0] REG_TURN_GAIN  = 3'd0;
   localparam logic [2:0] REG_TURN_LIMIT = 3'd1;
   localparam logic [2:0] REG_DRIVE_GAIN = 3'd2;
   localparam logic [2:0] REG_DRIVE_LIM  = 3'd3;
   localparam logic [2:0] REG_HEAD_THR   = 3'd4;
   localparam logic [2:0] REG_SLOW_FACT  = 3'd5;

   localparam int ANG_PAD = MERGE_STAGE - 3 - cordic_lat(ANGLE_ITERATIONS);

   // configuration registers
   logic [15:0] turn_gain_ff, drive_gain_ff, slow_factor_ff;
   logic [14:0] turn_limit_ff, heading_thr_ff;
   logic [23:0] drive_limit_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign busy      = reset;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_gain_ff   <= 16'd768;
         turn_limit_ff  <= 15'd4096;
         drive_gain_ff  <= 16'd2048;
         drive_limit_ff <= 24'd262144;
         heading_thr_ff <= 15'd4096;
         slow_factor_ff <= 16'd655;
      end else if (csr_write) begin
         case (paddr[4:2])
            REG_TURN_GAIN:  turn_gain_ff   <= pwdata[15:0];
            REG_TURN_LIMIT: turn_limit_ff  <= pwdata[14:0];
            REG_DRIVE_GAIN: drive_gain_ff  <= pwdata[15:0];
            REG_DRIVE_LIM:  drive_limit_ff <= pwdata[23:0];
            REG_HEAD_THR:   heading_thr_ff <= pwdata[14:0];
            REG_SLOW_FACT:  slow_factor_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_TURN_GAIN:  prdata = 32'(turn_gain_ff);
         REG_TURN_LIMIT: prdata = 32'(turn_limit_ff);
         REG_DRIVE_GAIN: prdata = 32'(drive_gain_ff);
         REG_DRIVE_LIM:  prdata = 32'(drive_limit_ff);
         REG_HEAD_THR:   prdata = 32'(heading_thr_ff);
         REG_SLOW_FACT:  prdata = 32'(slow_factor_ff);
         default:        prdata = '0;
      endcase
   end

   // stage valids of the register stages outside the long units
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic f_vld_ff, g_vld_ff, r_vld_ff, s_vld_ff, t_vld_ff;

   // stage A: captured transaction
   logic signed [31:0] a_rx_ff, a_ry_ff, a_gx_ff, a_gy_ff;
   logic signed [15:0] a_qx_ff, a_qy_ff, a_qz_ff, a_qw_ff;

   // stage B: differences and quaternion products
   logic signed [32:0] b_dx_in, b_dy_in, b_dx_ff, b_dy_ff;
   logic signed [31:0] b_pwz_ff, b_pxy_ff, b_pyy_ff, b_pzz_ff;

   // stage C: rotator operands, magnitudes halved when either reaches 2^31
   logic signed [DIFF_W-1:0] c_yaw_x_in, c_yaw_y_in, c_yaw_x_ff, c_yaw_y_ff;
   logic signed [DIFF_W-1:0] c_dx_ff, c_dy_ff;
   logic [32:0]              ax_w, ay_w;
   logic                     c_halved_in, c_halved_ff;
   logic [30:0]              c_hax_in, c_hay_in, c_hax_ff, c_hay_ff;

   // stage D: squares
   logic [61:0] d_sqx_ff, d_sqy_ff;
   logic        d_halved_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start & ~busy;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   always_comb begin
      b_dx_in = 33'(a_gx_ff) - 33'(a_rx_ff);
      b_dy_in = 33'(a_gy_ff) - 33'(a_ry_ff);
   end

   always_comb begin
      c_yaw_y_in  = (DIFF_W'(b_pwz_ff) + DIFF_W'(b_pxy_ff)) <<< 1;
      c_yaw_x_in  = (DIFF_W'(1) <<< 28) - ((DIFF_W'(b_pyy_ff) + DIFF_W'(b_pzz_ff)) <<< 1);
      ax_w        = b_dx_ff[32] ? $unsigned(-b_dx_ff) : $unsigned(b_dx_ff);
      ay_w        = b_dy_ff[32] ? $unsigned(-b_dy_ff) : $unsigned(b_dy_ff);
      c_halved_in = ax_w[31] | ay_w[31];
      c_hax_in    = c_halved_in ? ax_w[31:1] : ax_w[30:0];
      c_hay_in    = c_halved_in ? ay_w[31:1] : ay_w[30:0];
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         a_rx_ff <= req_robot_x;
         a_ry_ff <= req_robot_y;
         a_gx_ff <= req_goal_x;
         a_gy_ff <= req_goal_y;
         a_qx_ff <= req_quat_x;
         a_qy_ff <= req_quat_y;
         a_qz_ff <= req_quat_z;
         a_qw_ff <= req_quat_w;
      end
      b_dx_ff     <= b_dx_in;
      b_dy_ff     <= b_dy_in;
      b_pwz_ff    <= 32'(a_qw_ff) * 32'(a_qz_ff);
      b_pxy_ff    <= 32'(a_qx_ff) * 32'(a_qy_ff);
      b_pyy_ff    <= 32'(a_qy_ff) * 32'(a_qy_ff);
      b_pzz_ff    <= 32'(a_qz_ff) * 32'(a_qz_ff);
      c_yaw_x_ff  <= c_yaw_x_in;
      c_yaw_y_ff  <= c_yaw_y_in;
      c_dx_ff     <= DIFF_W'(b_dx_ff);
      c_dy_ff     <= DIFF_W'(b_dy_ff);
      c_halved_ff <= c_halved_in;
      c_hax_ff    <= c_hax_in;
      c_hay_ff    <= c_hay_in;
      d_sqx_ff    <= 62'(c_hax_ff) * 62'(c_hax_ff);
      d_sqy_ff    <= 62'(c_hay_ff) * 62'(c_hay_ff);
      d_halved_ff <= c_halved_ff;
   end

   // yaw and bearing
   logic                    yaw_vld, brg_vld;
   logic signed [ANG_W-1:0] yaw_ang, brg_ang;
   logic                    ang_vld;
   logic [2*ANG_W-1:0]      ang_data;

   wvc_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_x      (c_yaw_x_ff),
      .in_y      (c_yaw_y_ff),
      .out_valid (yaw_vld),
      .out_angle (yaw_ang)
   );

   wvc_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_bearing (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_x      (c_dx_ff),
      .in_y      (c_dy_ff),
      .out_valid (brg_vld),
      .out_angle (brg_ang)
   );

   wvc_delay #(.WIDTH(2 * ANG_W), .DEPTH(ANG_PAD)) u_ang_dly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yaw_vld & brg_vld),
      .in_data   ({yaw_ang, brg_ang}),
      .out_valid (ang_vld),
      .out_data  (ang_data)
   );

   // distance
   logic              isq_vld, hv_vld;
   logic [ROOT_W-1:0] isq_root;
   logic              hv_data;

   wvc_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .in_value  (SQ_IN_W'(d_sqx_ff) + SQ_IN_W'(d_sqy_ff)),
      .out_valid (isq_vld),
      .out_root  (isq_root)
   );

   wvc_delay #(.WIDTH(1), .DEPTH(ISQ_LAT)) u_half_dly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .in_data   (d_halved_ff),
      .out_valid (hv_vld),
      .out_data  (hv_data)
   );

   // merge: heading error with a single wrap
   logic signed [ERR_W-1:0] m_err;
   logic [DIST_W-1:0]       m_dist;
   logic signed [ERR_W-1:0] f_err_ff;
   logic [DIST_W-1:0]       f_dist_ff;

   always_comb begin
      m_err = ERR_W'($signed(ang_data[ANG_W-1:0])) -
              ERR_W'($signed(ang_data[2*ANG_W-1:ANG_W]));
      if (m_err < -PI_Q13) begin
         m_err = m_err + TWO_PI_Q13;
      end else if (m_err > PI_Q13) begin
         m_err = m_err - TWO_PI_Q13;
      end
      m_dist = hv_data ? {isq_root, 1'b0} : {1'b0, isq_root};
   end

   // stage G: magnitudes and products
   logic [MAG_W-1:0] g_mag_in, g_mag_ff;
   logic             g_neg_ff;
   logic [48:0]      g_prod_ff;
   logic [35:0]      g_e2_ff;
   logic [33:0]      g_tprod_ff;

   assign g_mag_in = f_err_ff[ERR_W-1] ? MAG_W'(-f_err_ff) : MAG_W'(f_err_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= isq_vld & ang_vld & hv_vld;
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_err_ff   <= m_err;
      f_dist_ff  <= m_dist;
      g_mag_ff   <= g_mag_in;
      g_neg_ff   <= f_err_ff[ERR_W-1];
      g_prod_ff  <= 49'(drive_gain_ff) * 49'(f_dist_ff);
      g_e2_ff    <= 36'(g_mag_in) * 36'(g_mag_in);
      g_tprod_ff <= 34'(g_mag_in) * 34'(turn_gain_ff);
   end

   // divider operands and the turn command, which rides alongside the divider
   logic [NUM_W-1:0]   h_num;
   logic [DEN_W-1:0]   h_den;
   logic [25:0]        h_t;
   logic [14:0]        h_tcl;
   logic signed [15:0] h_turn;
   logic               h_slow;
   logic               div_vld, side_vld;
   logic [QUO_W-1:0]   div_quo;
   logic [16:0]        side_data;

   always_comb begin
      h_num  = {g_prod_ff, 5'b0};
      h_den  = DEN_W'(8192) + DEN_W'(g_e2_ff >> 13);
      h_t    = g_tprod_ff[33:8];
      h_tcl  = (h_t > 26'(turn_limit_ff)) ? turn_limit_ff : h_t[14:0];
      h_turn = g_neg_ff ? -$signed(16'(h_tcl)) : $signed(16'(h_tcl));
      h_slow = g_mag_ff > MAG_W'(heading_thr_ff);
   end

   wvc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_vld_ff),
      .in_num    (h_num),
      .in_den    (h_den),
      .out_valid (div_vld),
      .out_quo   (div_quo)
   );

   wvc_delay #(.WIDTH(17), .DEPTH(DIV_LAT)) u_side_dly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_vld_ff),
      .in_data   ({h_slow, h_turn}),
      .out_valid (side_vld),
      .out_data  (side_data)
   );

   // clamp, slow down, drive out
   logic [23:0]        r_speed_ff, s_speed_ff, rsp_speed_ff;
   logic signed [15:0] r_turn_ff, s_turn_ff, rsp_turn_ff;
   logic               r_slow_ff, s_slow_ff;
   logic [39:0]        s_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         t_vld_ff <= 1'b0;
      end else begin
         r_vld_ff <= div_vld & side_vld;
         s_vld_ff <= r_vld_ff;
         t_vld_ff <= s_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      r_speed_ff   <= (div_quo > QUO_W'(drive_limit_ff)) ? drive_limit_ff : div_quo[23:0];
      r_turn_ff    <= $signed(side_data[15:0]);
      r_slow_ff    <= side_data[16];
      s_prod_ff    <= 40'(r_speed_ff) * 40'(slow_factor_ff);
      s_speed_ff   <= r_speed_ff;
      s_turn_ff    <= r_turn_ff;
      s_slow_ff    <= r_slow_ff;
      rsp_speed_ff <= s_slow_ff ? s_prod_ff[39:16] : s_speed_ff;
      rsp_turn_ff  <= s_turn_ff;
   end

   assign rsp_valid         = t_vld_ff;
   assign rsp_forward_speed = rsp_speed_ff;
   assign rsp_turn_rate     = rsp_turn_ff;
endmodule

@@ hdl/wvc_checker.sv @@
// Port-level checks for the waypoint velocity controller, bound to the top level.
// Depends on wvc_pkg for the fixed pipeline latency.
module wvc_checker
   import wvc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [15:0] rsp_turn_rate,
   input logic               pready
);
   // every result traces back to a transaction taken a fixed time earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without a matching transaction");

   // reset flushes the pipeline
   a_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result straight after reset");

   // the clamped turn rate never reaches the most negative code
   a_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_turn_rate != {1'b1, 15'b0}))
      else $error("turn rate outside its clamp");

   // the pipeline never refuses a transaction outside reset
   a_ready: assert property (@(posedge clock) !reset |-> (!busy && pready))
      else $error("block not ready outside reset");
endmodule

bind waypoint_velocity_controller wvc_checker u_wvc_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for waypoint_velocity_controller: directed poses, then random ones.
// Holds its own model of the steering law. Depends on wvc_pkg and the block itself.
`timescale 1ns / 100ps

module tb_top;
   import wvc_pkg::*;

   localparam int ITERS      = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE     = PIPE_LATENCY + 20;
   localparam int N_DIRECTED = 15;
   localparam int N_RANDOM   = 450;

   localparam logic [4:0] ADDR_TURN_GAIN   = 5'd0;
   localparam logic [4:0] ADDR_TURN_LIMIT  = 5'd4;
   localparam logic [4:0] ADDR_DRIVE_GAIN  = 5'd8;
   localparam logic [4:0] ADDR_DRIVE_LIMIT = 5'd12;
   localparam logic [4:0] ADDR_HEAD_THRESH = 5'd16;
   localparam logic [4:0] ADDR_SLOW_FACTOR = 5'd20;
   localparam logic [4:0] ADDR_UNUSED      = 5'd28;

   localparam longint Q30_PI   = 64'sd3373259426;
   localparam int     Q13_PI   = 25736;
   localparam int     Q13_2PI  = 51472;
   localparam longint NORM_TOP_V = 64'sd1 << 39;

   typedef struct packed {
      logic signed [31:0] robot_x, robot_y;
      logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
      logic signed [31:0] goal_x, goal_y;
   } pose_type;

   typedef struct packed {
      logic [23:0]        forward_speed;
      logic signed [15:0] turn_rate;
   } command_type;

   typedef struct packed {
      pose_type    pose;
      bit          known;
      command_type cmd;
   } pose_row_type;

   logic clock = 1'b0, reset = 1'b1, start = 1'b0;
   logic busy, rsp_valid, pready;
   logic signed [31:0] req_robot_x = '0, req_robot_y = '0, req_goal_x = '0, req_goal_y = '0;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic [23:0] rsp_forward_speed;
   logic signed [15:0] rsp_turn_rate;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;

   // hand-typed command for the current transaction, sent alongside the pose
   bit known_row = 1'b0;
   command_type known_cmd = '0;

   longint unsigned turn_gain_r, turn_limit_r, drive_gain_r, drive_limit_r;
   longint unsigned head_thresh_r, slow_factor_r;

   command_type cmd_expect[$];
   int fail_count = 0;
   int idle_cycles = 0;

   longint atan_tab[24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   pose_row_type directed[N_DIRECTED];

   waypoint_velocity_controller dut (
      .clock, .reset, .start, .busy,
      .req_robot_x, .req_robot_y, .req_quat_x, .req_quat_y, .req_quat_z, .req_quat_w,
      .req_goal_x, .req_goal_y,
      .rsp_valid, .rsp_forward_speed, .rsp_turn_rate,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // vectoring rotation: atan2(y, x) in Q3.13
   function automatic int vector_angle(longint x, longint y);
      longint z, m, xs, ys;
      z = 0;
      m = (abs64(x) > abs64(y)) ? abs64(x) : abs64(y);
      if (m != 0) begin
         while (m < NORM_TOP_V) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
         end
      end
      if (x < 0) begin
         z = (y >= 0) ? Q30_PI : -Q30_PI;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < ITERS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_tab[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_tab[i];
         end
      end
      return int'((z + 65536) >>> 17);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic command_type steer_command(pose_type p);
      longint dx, dy, qx, qy, qz, qw, yaw_y, yaw_x;
      longint unsigned ax, ay, distance, mag, den, v, t;
      int yaw, bearing, err;
      bit halved;
      command_type c;
      dx = longint'(p.goal_x) - longint'(p.robot_x);
      dy = longint'(p.goal_y) - longint'(p.robot_y);
      ax = abs64(dx);
      ay = abs64(dy);
      halved = (ax >= 64'd2147483648) || (ay >= 64'd2147483648);
      if (halved) begin
         ax = ax >> 1;
         ay = ay >> 1;
      end
      distance = int_sqrt(ax * ax + ay * ay);
      if (halved) distance = distance << 1;
      qx = longint'(p.quat_x);
      qy = longint'(p.quat_y);
      qz = longint'(p.quat_z);
      qw = longint'(p.quat_w);
      yaw_y = 2 * (qw * qz + qx * qy);
      yaw_x = (64'sd1 << 28) - 2 * (qy * qy + qz * qz);
      yaw = vector_angle(yaw_x, yaw_y);
      bearing = vector_angle(dx, dy);
      err = bearing - yaw;
      if (err < -Q13_PI) err = err + Q13_2PI;
      else if (err > Q13_PI) err = err - Q13_2PI;
      mag = (err < 0) ? 64'(-err) : 64'(err);
      den = 8192 + ((mag * mag) >> 13);
      v = ((drive_gain_r * distance) << 5) / den;
      if (v > drive_limit_r) v = drive_limit_r;
      if (mag > head_thresh_r) v = (v * slow_factor_r) >> 16;
      t = (mag * turn_gain_r) >> 8;
      if (t > turn_limit_r) t = turn_limit_r;
      c.forward_speed = v[23:0];
      c.turn_rate = (err < 0) ? -$signed(t[15:0]) : $signed(t[15:0]);
      return c;
   endfunction

   function automatic pose_row_type mk_row(longint rx, longint ry, int qx, int qy, int qz,
                                           int qw, longint gx, longint gy, bit known,
                                           int spd, int trn);
      pose_row_type r;
      r.pose = '{robot_x: 32'(rx), robot_y: 32'(ry), quat_x: 16'(qx), quat_y: 16'(qy),
                 quat_z: 16'(qz), quat_w: 16'(qw), goal_x: 32'(gx), goal_y: 32'(gy)};
      r.known = known;
      r.cmd = '{forward_speed: 24'(spd), turn_rate: 16'(trn)};
      return r;
   endfunction

   function automatic pose_type random_pose();
      pose_type p;
      int unsigned kind, span;
      kind = $urandom_range(0, 9);
      p.quat_x = 16'($urandom_range(0, 32768) - 16384);
      p.quat_y = 16'($urandom_range(0, 32768) - 16384);
      p.quat_z = 16'($urandom_range(0, 32768) - 16384);
      p.quat_w = 16'($urandom_range(0, 32768) - 16384);
      p.robot_x = $urandom;
      p.robot_y = $urandom;
      if (kind < 2) begin
         // full-range noise, halving path likely
         p.goal_x = $urandom;
         p.goal_y = $urandom;
      end else if (kind == 2) begin
         p.goal_x = p.robot_x;
         p.goal_y = p.robot_y;
      end else begin
         // mostly planar yaw with waypoints a few metres off
         if (kind < 7) begin
            p.quat_x = 16'($urandom_range(0, 800) - 400);
            p.quat_y = 16'($urandom_range(0, 800) - 400);
         end
         span = 1 << $urandom_range(4, 22);
         p.robot_x = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         p.robot_y = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         p.goal_x = p.robot_x + $signed($urandom_range(0, 2 * span)) - $signed(span);
         p.goal_y = p.robot_y + $signed($urandom_range(0, 2 * span)) - $signed(span);
      end
      return p;
   endfunction

   task automatic csr_write(logic [4:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (addr)
         ADDR_TURN_GAIN:   turn_gain_r   = 64'(data[15:0]);
         ADDR_TURN_LIMIT:  turn_limit_r  = 64'(data[14:0]);
         ADDR_DRIVE_GAIN:  drive_gain_r  = 64'(data[15:0]);
         ADDR_DRIVE_LIMIT: drive_limit_r = 64'(data[23:0]);
         ADDR_HEAD_THRESH: head_thresh_r = 64'(data[14:0]);
         ADDR_SLOW_FACTOR: slow_factor_r = 64'(data[15:0]);
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [31:0] tg, logic [31:0] tl, logic [31:0] dg,
                                logic [31:0] dl, logic [31:0] ht, logic [31:0] sf);
      csr_write(ADDR_TURN_GAIN, tg);
      csr_write(ADDR_TURN_LIMIT, tl);
      csr_write(ADDR_DRIVE_GAIN, dg);
      csr_write(ADDR_DRIVE_LIMIT, dl);
      csr_write(ADDR_HEAD_THRESH, ht);
      csr_write(ADDR_SLOW_FACTOR, sf);
      csr_write(ADDR_UNUSED, $urandom);
   endtask

   // present one pose and hold it until taken; busy is sampled mid-cycle
   task automatic send_pose(pose_type p, bit known, command_type cmd);
      bit taken;
      req_robot_x <= p.robot_x;
      req_robot_y <= p.robot_y;
      req_quat_x  <= p.quat_x;
      req_quat_y  <= p.quat_y;
      req_quat_z  <= p.quat_z;
      req_quat_w  <= p.quat_w;
      req_goal_x  <= p.goal_x;
      req_goal_y  <= p.goal_y;
      known_row   <= known;
      known_cmd   <= cmd;
      start       <= 1'b1;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   int burst_left = 0;

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (cmd_expect.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) begin
         send_pose(random_pose(), 1'b0, '0);
         pace();
      end
      drain();
   endtask

   always @(posedge clock) begin
      command_type exp_cmd;
      if (!reset) begin
         if (rsp_valid) begin
            if (cmd_expect.size() == 0) begin
               $error("unexpected command: speed %0d turn %0d", rsp_forward_speed,
                      rsp_turn_rate);
               fail_count++;
            end else begin
               exp_cmd = cmd_expect.pop_front();
               if (rsp_forward_speed !== exp_cmd.forward_speed) begin
                  $error("forward_speed: expected %0d, got %0d", exp_cmd.forward_speed,
                         rsp_forward_speed);
                  fail_count++;
               end
               if (rsp_turn_rate !== exp_cmd.turn_rate) begin
                  $error("turn_rate: expected %0d, got %0d", exp_cmd.turn_rate,
                         rsp_turn_rate);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            cmd_expect.push_back(known_row ? known_cmd : steer_command('{
               robot_x: req_robot_x, robot_y: req_robot_y, quat_x: req_quat_x,
               quat_y: req_quat_y, quat_z: req_quat_z, quat_w: req_quat_w,
               goal_x: req_goal_x, goal_y: req_goal_y}));
         end
      end
      if ((start && !busy) || rsp_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("waypoint_velocity_controller test failed");
         $finish;
      end
   end

   initial begin
      turn_gain_r   = 768;
      turn_limit_r  = 4096;
      drive_gain_r  = 2048;
      drive_limit_r = 262144;
      head_thresh_r = 4096;
      slow_factor_r = 655;

      // zero vector: bearing is the full table sum, so the turn saturates positive
      directed[0]  = mk_row(0, 0, 0, 0, 0, 16384, 0, 0, 1, 0, 4096);
      directed[1]  = mk_row(0, 0, 0, 0, 0, 16384, 65536, 0, 1, 262144, 0);
      directed[2]  = mk_row(-64'sd2147483648, -64'sd2147483648, 0, 0, 0, 16384,
                            64'sd2147483647, 64'sd2147483647, 0, 0, 0);
      directed[3]  = mk_row(64'sd2147483647, 64'sd2147483647, 0, 0, 0, 16384,
                            -64'sd2147483648, -64'sd2147483648, 0, 0, 0);
      directed[4]  = mk_row(0, 0, 0, 0, 0, 16384, -65536, 0, 0, 0, 0);
      directed[5]  = mk_row(0, 0, 0, 0, 0, 16384, 0, 65536, 0, 0, 0);
      directed[6]  = mk_row(0, 0, 0, 0, 0, 16384, 0, -65536, 0, 0, 0);
      directed[7]  = mk_row(100, -100, 16384, 16384, 16384, 16384, 300000, 5000, 0, 0, 0);
      directed[8]  = mk_row(-7, 9, -16384, -16384, -16384, -16384, -90000, 70000, 0, 0, 0);
      directed[9]  = mk_row(0, 0, 0, 0, 0, 0, 65536, 65536, 0, 0, 0);
      directed[10] = mk_row(0, 0, 0, 0, 16384, 0, 65536, 0, 0, 0, 0);
      directed[11] = mk_row(0, 0, 0, 0, -16384, 0, 65536, 1, 0, 0, 0);
      directed[12] = mk_row(0, 0, 16384, 0, 0, 0, 0, -200000, 0, 0, 0);
      directed[13] = mk_row(123456, -654321, 1000, -2000, 9000, 12000, 123456, -654321,
                            0, 0, 0);
      directed[14] = mk_row(5, 5, 0, 0, 0, 16384, 6, 5, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < N_DIRECTED; n++) begin
         send_pose(directed[n].pose, directed[n].known, directed[n].cmd);
         pace();
      end
      drain();
      random_phase(N_RANDOM / 5);

      load_settings(0, 0, 0, 0, 0, 0);
      random_phase(N_RANDOM / 5);

      load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_phase(N_RANDOM / 5);

      load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_phase(N_RANDOM / 5);

      // moderate gains with a tight threshold so both speed branches show up
      load_settings($urandom_range(256, 2048), $urandom_range(2000, 20000),
                    $urandom_range(256, 8192), $urandom_range(65536, 2000000),
                    $urandom_range(100, 3000), $urandom_range(1000, 60000));
      random_phase(N_RANDOM / 5);

      if (fail_count == 0) begin
         $display("waypoint_velocity_controller test passed");
      end else begin
         $display("waypoint_velocity_controller test failed");
      end
      $finish;
   end

endmodule
